@@ src/mpfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpfd_pkg
// shared constants, types and helpers of the page framebuffer drawing engine
// ----------------------------------------------------------------------------
`default_nettype none

package mpfd_pkg;

  localparam int SCREEN_COLS = 128;
  localparam int SCREEN_ROWS = 64;
  localparam int PAGE_ROWS   = 8;
  localparam int PAGE_COUNT  = (SCREEN_ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_DEPTH = SCREEN_COLS * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PAGE_W      = 5;

  localparam logic [8:0] COLS_LIM  = 9'(SCREEN_COLS);
  localparam logic [8:0] ROWS_LIM  = 9'(SCREEN_ROWS);
  localparam logic [8:0] PAGES_LIM = 9'(PAGE_COUNT);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_FILL   = 3'd1,
    OP_INVERT = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_FIN
  } st_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       status;
  } res_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W-1:0] page,
                                                input logic [7:0] col);
    addr_of = ADDR_W'(32'(page) * SCREEN_COLS + 32'(col));
  endfunction

endpackage

`default_nettype wire

@@ src/mpfd_ram.sv @@
// ----------------------------------------------------------------------------
// mpfd_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mpfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/mpfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpfd_ctrl
// command decode, clearing sweep and byte-wise read-modify-write walker
// ----------------------------------------------------------------------------
`default_nettype none

module mpfd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          opcode_i,
  input  wire logic [7:0]          col_i,
  input  wire logic [7:0]          row_i,
  input  wire logic [7:0]          rect_width_i,
  input  wire logic [7:0]          rect_height_i,
  input  wire logic                pixel_on_i,
  output logic                     res_valid_o,
  output mpfd_pkg::res_t           res_o,
  input  wire logic                res_load_i,
  output mpfd_pkg::mem_req_t       mem_req_o,
  input  wire logic [7:0]          rdata_i
);

  mpfd_pkg::st_e state_q, state_d;
  logic [mpfd_pkg::ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic clr_cmd_q, clr_cmd_d;

  mpfd_pkg::op_e op_q;
  logic       lit_q;
  logic [7:0] col_q, col_end_q;
  logic [mpfd_pkg::PAGE_W-1:0] page_q, page_first_q, page_last_q;
  logic [2:0] top_q, bot_q;
  logic       status_q;
  logic [7:0] byte_q;

  mpfd_pkg::op_e in_op;
  logic accept;
  logic pix_oob, rect_oob, rect_empty, read_oob, reject;
  logic [7:0] rect_bot, rect_right;
  logic walk_last;
  logic [2:0] lo, hi;
  logic [7:0] mask, new_byte;
  logic [mpfd_pkg::ADDR_W-1:0] walk_addr;

  assign in_op  = mpfd_pkg::op_e'(opcode_i);
  assign accept = in_valid_i && (state_q == mpfd_pkg::ST_IDLE);

  assign pix_oob  = ({1'b0, col_i} >= mpfd_pkg::COLS_LIM) ||
                    ({1'b0, row_i} >= mpfd_pkg::ROWS_LIM);
  assign rect_oob = pix_oob ||
                    (({1'b0, col_i} + {1'b0, rect_width_i}) > mpfd_pkg::COLS_LIM) ||
                    (({1'b0, row_i} + {1'b0, rect_height_i}) > mpfd_pkg::ROWS_LIM);
  assign rect_empty = (rect_width_i == 8'd0) || (rect_height_i == 8'd0);
  assign read_oob = ({1'b0, col_i} >= mpfd_pkg::COLS_LIM) ||
                    ({1'b0, row_i} >= mpfd_pkg::PAGES_LIM);
  assign rect_bot   = row_i + rect_height_i - 8'd1;
  assign rect_right = col_i + rect_width_i - 8'd1;

  always_comb begin
    unique case (in_op) inside
      mpfd_pkg::OP_SET:    reject = pix_oob;
      mpfd_pkg::OP_FILL,
      mpfd_pkg::OP_INVERT: reject = rect_oob;
      mpfd_pkg::OP_READ:   reject = read_oob;
      default:             reject = 1'b0;
    endcase
  end

  // walk order: pages of a column first, then the next column
  assign walk_last = (page_q == page_last_q) && (col_q == col_end_q);
  assign walk_addr = mpfd_pkg::addr_of(page_q, col_q);
  assign lo = (page_q == page_first_q) ? top_q : 3'd0;
  assign hi = (page_q == page_last_q) ? bot_q : 3'd7;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i] = (3'(i) >= lo) && (3'(i) <= hi);
    end
  end

  always_comb begin
    if (op_q == mpfd_pkg::OP_INVERT) begin
      new_byte = rdata_i ^ mask;
    end else if (lit_q) begin
      new_byte = rdata_i | mask;
    end else begin
      new_byte = rdata_i & ~mask;
    end
  end

  // next state
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    clr_cmd_d  = clr_cmd_q;
    unique case (state_q)
      mpfd_pkg::ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == mpfd_pkg::CLR_LAST) begin
          state_d = clr_cmd_q ? mpfd_pkg::ST_FIN : mpfd_pkg::ST_IDLE;
        end
      end
      mpfd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_op) inside
            mpfd_pkg::OP_SET: begin
              state_d = reject ? mpfd_pkg::ST_FIN : mpfd_pkg::ST_RD;
            end
            mpfd_pkg::OP_FILL,
            mpfd_pkg::OP_INVERT: begin
              state_d = (reject || rect_empty) ? mpfd_pkg::ST_FIN : mpfd_pkg::ST_RD;
            end
            mpfd_pkg::OP_READ: begin
              state_d = reject ? mpfd_pkg::ST_FIN : mpfd_pkg::ST_RD;
            end
            mpfd_pkg::OP_CLEAR: begin
              state_d    = mpfd_pkg::ST_CLEAR;
              clr_addr_d = '0;
              clr_cmd_d  = 1'b1;
            end
            default: state_d = mpfd_pkg::ST_FIN;
          endcase
        end
      end
      mpfd_pkg::ST_RD: state_d = mpfd_pkg::ST_WR;
      mpfd_pkg::ST_WR: begin
        if ((op_q == mpfd_pkg::OP_READ) || walk_last) begin
          state_d = mpfd_pkg::ST_FIN;
        end else begin
          state_d = mpfd_pkg::ST_RD;
        end
      end
      mpfd_pkg::ST_FIN: begin
        if (res_load_i) begin
          state_d = mpfd_pkg::ST_IDLE;
        end
      end
      default: state_d = mpfd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o      = (state_q != mpfd_pkg::ST_IDLE);
    res_valid_o     = (state_q == mpfd_pkg::ST_FIN);
    res_o.read_byte = byte_q;
    res_o.status    = status_q;
    mem_req_o.raddr = walk_addr;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = walk_addr;
    mem_req_o.wdata = new_byte;
    if (state_q == mpfd_pkg::ST_CLEAR) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.waddr = clr_addr_q;
      mem_req_o.wdata = 8'd0;
    end else if ((state_q == mpfd_pkg::ST_WR) && (op_q != mpfd_pkg::OP_READ)) begin
      mem_req_o.we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mpfd_pkg::ST_CLEAR;
      clr_addr_q <= '0;
      clr_cmd_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      clr_cmd_q  <= clr_cmd_d;
    end
  end

  // command and walk registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_op;
      lit_q    <= pixel_on_i;
      col_q    <= col_i;
      status_q <= reject;
      byte_q   <= 8'd0;
      top_q    <= row_i[2:0];
      if (in_op == mpfd_pkg::OP_READ) begin
        page_q       <= row_i[mpfd_pkg::PAGE_W-1:0];
        page_first_q <= row_i[mpfd_pkg::PAGE_W-1:0];
        page_last_q  <= row_i[mpfd_pkg::PAGE_W-1:0];
        col_end_q    <= col_i;
        bot_q        <= row_i[2:0];
      end else if (in_op == mpfd_pkg::OP_SET) begin
        page_q       <= row_i[7:3];
        page_first_q <= row_i[7:3];
        page_last_q  <= row_i[7:3];
        col_end_q    <= col_i;
        bot_q        <= row_i[2:0];
      end else begin
        page_q       <= row_i[7:3];
        page_first_q <= row_i[7:3];
        page_last_q  <= rect_bot[7:3];
        col_end_q    <= rect_right;
        bot_q        <= rect_bot[2:0];
      end
    end else if (state_q == mpfd_pkg::ST_WR) begin
      if (op_q == mpfd_pkg::OP_READ) begin
        byte_q <= rdata_i;
      end else if (!walk_last) begin
        if (page_q == page_last_q) begin
          page_q <= page_first_q;
          col_q  <= col_q + 8'd1;
        end else begin
          page_q <= page_q + 1'b1;
        end
      end
    end else if ((state_q == mpfd_pkg::ST_CLEAR) && clr_cmd_q) begin
      status_q <= 1'b0;
      byte_q   <= 8'd0;
    end
  end

endmodule

`default_nettype wire

@@ src/mono_page_framebuffer_draw.sv @@
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw
// 1 bit per pixel page framebuffer with pixel, rectangle, clear and read ops
// ----------------------------------------------------------------------------
// input channel: one command beat (opcode, col, row, rect size, pixel_on) per
// valid/stall handshake; in_stall_o is high while a command is in progress.
// output channel: exactly one result beat (read_byte, status) per command,
// held in an output register so the next command is taken while it waits.
// each touched byte costs a read-modify-write on the store ram (ST_RD, ST_WR):
//   set pixel / read byte: a single byte is visited (read byte writes nothing)
//   fill / invert: every byte of the columns and pages spanned, in turn
//   clear all: a sweep over all 1024 bytes, one byte written per cycle
//   rejected, empty or unused commands: no ram access, straight to the result
// after reset the block runs a clearing pass over all 1024 bytes with
// in_stall_o high, then starts taking commands. a stalled result beat is held
// on the output; once the output register is full and stalled, a finished
// command waits in the sequencer and no new command is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_page_framebuffer_draw (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] in_opcode_i,
  input  wire logic [7:0] in_col_i,
  input  wire logic [7:0] in_row_i,
  input  wire logic [7:0] in_rect_width_i,
  input  wire logic [7:0] in_rect_height_i,
  input  wire logic       in_pixel_on_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_read_byte_o,
  output logic            out_status_o
);

  mpfd_pkg::mem_req_t mem_req;
  mpfd_pkg::res_t     res;
  logic [7:0] rdata;
  logic res_valid, res_load;
  logic out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic out_status_q;

  mpfd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (in_opcode_i),
    .col_i         (in_col_i),
    .row_i         (in_row_i),
    .rect_width_i  (in_rect_width_i),
    .rect_height_i (in_rect_height_i),
    .pixel_on_i    (in_pixel_on_i),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_load_i    (res_load),
    .mem_req_o     (mem_req),
    .rdata_i       (rdata)
  );

  mpfd_ram #(
    .Width (8),
    .Depth (mpfd_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // output register frees up when its beat is taken
  assign res_load = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_byte_q   <= res.read_byte;
      out_status_q <= res.status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_read_byte_o = out_byte_q;
  assign out_status_o    = out_status_q;

`ifndef NO_ASSERTIONS
  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> in_stall_o)
    else $error("store written while a command is accepted");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("command accepted without the sequencer going busy");

  a_reject_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o) |-> (out_read_byte_o == 8'd0))
    else $error("rejected command returned a non-zero byte");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_byte_q))
    else $error("held result beat overwritten");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// exercises the page framebuffer drawing engine with directed and random
// commands, predicting each result beat from a private copy of the frame store
// ----------------------------------------------------------------------------

module testbench;

  localparam int     NUM_ITEMS   = 1900;
  localparam int     TAIL_ITEMS  = 150;
  localparam int     HOLD_CYCLES = 1500;
  localparam int     HOLD_AFTER  = 300;
  localparam int     END_DRAIN   = 64;
  localparam int     MAX_REPORTS = 10;
  localparam longint LIMIT_TIME  = 64'd300_000_000;

  // opcodes with no command behind them
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] col, row, width, height;
    logic       lit;
  } draw_cmd_t;

  bit         clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] in_opcode_i;
  logic [7:0] in_col_i, in_row_i, in_rect_width_i, in_rect_height_i;
  logic       in_pixel_on_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_read_byte_o;
  logic       out_status_o;

  mono_page_framebuffer_draw u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_opcode_i      (in_opcode_i),
    .in_col_i         (in_col_i),
    .in_row_i         (in_row_i),
    .in_rect_width_i  (in_rect_width_i),
    .in_rect_height_i (in_rect_height_i),
    .in_pixel_on_i    (in_pixel_on_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_read_byte_o  (out_read_byte_o),
    .out_status_o     (out_status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [7:0]       pix_store [mpfd_pkg::STORE_DEPTH];
  draw_cmd_t        cmd_q [$];
  mpfd_pkg::res_t   result_due_q [$];

  int   total_cmds;
  int   n_accepted, n_results, n_errors, n_rejected, n_reads;
  int   op_seen [8];
  logic run_en, in_taken, long_hold;
  int   idle_left, stall_left;

  function automatic mpfd_pkg::res_t draw_and_predict(draw_cmd_t c);
    mpfd_pkg::res_t res;
    int   x, y, idx;
    logic fits;
    res  = '0;
    fits = c.col < mpfd_pkg::SCREEN_COLS && c.row < mpfd_pkg::SCREEN_ROWS
           && int'(c.col) + int'(c.width) <= mpfd_pkg::SCREEN_COLS
           && int'(c.row) + int'(c.height) <= mpfd_pkg::SCREEN_ROWS;
    case (c.opcode) inside
      mpfd_pkg::OP_SET: begin
        if (c.col >= mpfd_pkg::SCREEN_COLS || c.row >= mpfd_pkg::SCREEN_ROWS) begin
          res.status = 1'b1;
        end else begin
          idx = int'(c.row) / mpfd_pkg::PAGE_ROWS * mpfd_pkg::SCREEN_COLS + int'(c.col);
          pix_store[idx][int'(c.row) % mpfd_pkg::PAGE_ROWS] = c.lit;
        end
      end
      mpfd_pkg::OP_FILL, mpfd_pkg::OP_INVERT: begin
        if (!fits) begin
          res.status = 1'b1;
        end else begin
          for (x = int'(c.col); x < int'(c.col) + int'(c.width); x++) begin
            for (y = int'(c.row); y < int'(c.row) + int'(c.height); y++) begin
              idx = y / mpfd_pkg::PAGE_ROWS * mpfd_pkg::SCREEN_COLS + x;
              if (c.opcode == mpfd_pkg::OP_FILL) begin
                pix_store[idx][y % mpfd_pkg::PAGE_ROWS] = c.lit;
              end else begin
                pix_store[idx][y % mpfd_pkg::PAGE_ROWS] =
                    ~pix_store[idx][y % mpfd_pkg::PAGE_ROWS];
              end
            end
          end
        end
      end
      mpfd_pkg::OP_CLEAR: begin
        foreach (pix_store[i]) pix_store[i] = '0;
      end
      mpfd_pkg::OP_READ: begin
        // row carries the page number here
        if (c.col >= mpfd_pkg::SCREEN_COLS || c.row >= mpfd_pkg::PAGE_COUNT) begin
          res.status = 1'b1;
        end else begin
          res.read_byte = pix_store[int'(c.row) * mpfd_pkg::SCREEN_COLS + int'(c.col)];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void queue_cmd(logic [2:0] op, int c, int r, int w, int h, logic lit);
    draw_cmd_t d;
    d.opcode = op;
    d.col    = 8'(c);
    d.row    = 8'(r);
    d.width  = 8'(w);
    d.height = 8'(h);
    d.lit    = lit;
    cmd_q.push_back(d);
  endfunction

  task automatic report_error(string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("error: %s", msg);
  endtask

  // command side: a beat stays put until taken, idle bursts only between beats
  always @(negedge clk_i) begin : drive_cmd
    draw_cmd_t nc;
    if (run_en && !(in_valid_i && !in_taken)) begin
      if (idle_left > 0) begin
        idle_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
        idle_left  = $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else begin
        nc = cmd_q.pop_front();
        in_valid_i       <= 1'b1;
        in_opcode_i      <= nc.opcode;
        in_col_i         <= nc.col;
        in_row_i         <= nc.row;
        in_rect_width_i  <= nc.width;
        in_rect_height_i <= nc.height;
        in_pixel_on_i    <= nc.lit;
      end
    end
  end

  // result side: short random stall bursts, plus the one long hold-off
  always @(negedge clk_i) begin : drive_stall
    logic s;
    s = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      s = 1'b1;
    end else if (n_results < total_cmds - TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      s = 1'b1;
    end
    out_stall_i <= s || long_hold;
  end

  initial begin : hold_off
    long_hold = 1'b0;
    while (n_accepted < HOLD_AFTER) @(negedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    long_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : watch
    draw_cmd_t      c;
    mpfd_pkg::res_t want;
    run_en   <= rst_ni;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      c.opcode = in_opcode_i;
      c.col    = in_col_i;
      c.row    = in_row_i;
      c.width  = in_rect_width_i;
      c.height = in_rect_height_i;
      c.lit    = in_pixel_on_i;
      want     = draw_and_predict(c);
      result_due_q.push_back(want);
      op_seen[c.opcode]++;
      if (want.status) n_rejected++;
      if (c.opcode == mpfd_pkg::OP_READ && !want.status) n_reads++;
      n_accepted <= n_accepted + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results <= n_results + 1;
      if (result_due_q.size() == 0) begin
        report_error($sformatf("result beat %0d with nothing expected (byte %02h status %0b)",
                               n_results, out_read_byte_o, out_status_o));
      end else begin
        want = result_due_q.pop_front();
        if (out_read_byte_o !== want.read_byte)
          report_error($sformatf("result %0d read_byte want %02h got %02h",
                                 n_results, want.read_byte, out_read_byte_o));
        if (out_status_o !== want.status)
          report_error($sformatf("result %0d status want %0b got %0b",
                                 n_results, want.status, out_status_o));
      end
    end
  end

  initial begin : stimulus
    int kind, c, r, w, h;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_opcode_i      = '0;
    in_col_i         = '0;
    in_row_i         = '0;
    in_rect_width_i  = '0;
    in_rect_height_i = '0;
    in_pixel_on_i    = 1'b0;
    out_stall_i      = 1'b0;
    run_en           = 1'b0;
    in_taken         = 1'b0;
    idle_left        = 0;
    stall_left       = 0;
    n_accepted       = 0;
    n_results        = 0;
    n_errors         = 0;
    n_rejected       = 0;
    n_reads          = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (pix_store[i]) pix_store[i] = '0;

    // corners, pixel off, off-screen pixels
    queue_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_SET, 0, 0, 0, 0, 1'b1);
    queue_cmd(mpfd_pkg::OP_SET, mpfd_pkg::SCREEN_COLS - 1, mpfd_pkg::SCREEN_ROWS - 1,
              255, 255, 1'b1);
    queue_cmd(mpfd_pkg::OP_READ, mpfd_pkg::SCREEN_COLS - 1, mpfd_pkg::PAGE_COUNT - 1,
              0, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_SET, 0, 0, 0, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_SET, mpfd_pkg::SCREEN_COLS, 0, 0, 0, 1'b1);
    queue_cmd(mpfd_pkg::OP_SET, 0, mpfd_pkg::SCREEN_ROWS, 0, 0, 1'b1);
    queue_cmd(mpfd_pkg::OP_SET, 255, 255, 255, 255, 1'b1);
    // whole screen, then an inverted window across a page boundary
    queue_cmd(mpfd_pkg::OP_FILL, 0, 0, mpfd_pkg::SCREEN_COLS, mpfd_pkg::SCREEN_ROWS, 1'b1);
    queue_cmd(mpfd_pkg::OP_READ, 64, 3, 0, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_INVERT, 10, 5, 20, 10, 1'b0);
    queue_cmd(mpfd_pkg::OP_READ, 10, 0, 0, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_READ, 29, 1, 0, 0, 1'b0);
    // empty rectangles, then rectangles hanging over an edge
    queue_cmd(mpfd_pkg::OP_FILL, 5, 5, 0, 3, 1'b0);
    queue_cmd(mpfd_pkg::OP_INVERT, 5, 5, 3, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_FILL, 100, 0, 29, 1, 1'b0);
    queue_cmd(mpfd_pkg::OP_FILL, 0, 60, 1, 5, 1'b0);
    queue_cmd(mpfd_pkg::OP_FILL, 0, 0, 255, 255, 1'b0);
    queue_cmd(mpfd_pkg::OP_INVERT, mpfd_pkg::SCREEN_COLS - 1, mpfd_pkg::SCREEN_ROWS - 1,
              2, 1, 1'b0);
    // off-screen reads and unused opcodes
    queue_cmd(mpfd_pkg::OP_READ, mpfd_pkg::SCREEN_COLS, 0, 0, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_READ, 0, mpfd_pkg::PAGE_COUNT, 0, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_READ, 0, 255, 0, 0, 1'b0);
    queue_cmd(OP_SPARE_A, 1, 1, 1, 1, 1'b1);
    queue_cmd(OP_SPARE_B, 200, 200, 200, 200, 1'b0);
    queue_cmd(OP_SPARE_C, 0, 0, 0, 0, 1'b1);
    queue_cmd(mpfd_pkg::OP_CLEAR, 0, 0, 0, 0, 1'b0);
    queue_cmd(mpfd_pkg::OP_READ, 64, 3, 0, 0, 1'b0);

    while (cmd_q.size() < NUM_ITEMS) begin
      kind = $urandom_range(0, 99);
      c    = $urandom_range(0, mpfd_pkg::SCREEN_COLS - 1);
      r    = $urandom_range(0, mpfd_pkg::SCREEN_ROWS - 1);
      if (kind < 30) begin
        queue_cmd(mpfd_pkg::OP_SET, c, r, $urandom_range(0, 255), $urandom_range(0, 255),
                  1'($urandom_range(0, 1)));
      end else if (kind < 60) begin
        queue_cmd(mpfd_pkg::OP_READ, c, $urandom_range(0, mpfd_pkg::PAGE_COUNT - 1),
                  0, 0, 1'b0);
      end else if (kind < 80) begin
        w = $urandom_range(0, (mpfd_pkg::SCREEN_COLS - c) < 16 ?
                              mpfd_pkg::SCREEN_COLS - c : 16);
        h = $urandom_range(0, (mpfd_pkg::SCREEN_ROWS - r) < 16 ?
                              mpfd_pkg::SCREEN_ROWS - r : 16);
        queue_cmd(kind < 70 ? mpfd_pkg::OP_FILL : mpfd_pkg::OP_INVERT, c, r, w, h,
                  1'($urandom_range(0, 1)));
      end else if (kind == 80) begin
        queue_cmd($urandom_range(0, 1) ? mpfd_pkg::OP_FILL : mpfd_pkg::OP_INVERT, c, r,
                  $urandom_range(0, mpfd_pkg::SCREEN_COLS - c),
                  $urandom_range(0, mpfd_pkg::SCREEN_ROWS - r),
                  1'($urandom_range(0, 1)));
      end else if (kind == 81) begin
        queue_cmd(mpfd_pkg::OP_CLEAR, c, r, 0, 0, 1'b0);
      end else if (kind < 92) begin
        queue_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end else begin
        // rectangles that end exactly on, or one past, the right or bottom edge
        if ($urandom_range(0, 1)) begin
          w = mpfd_pkg::SCREEN_COLS - c + $urandom_range(0, 1);
          h = $urandom_range(1, (mpfd_pkg::SCREEN_ROWS - r) < 8 ?
                                mpfd_pkg::SCREEN_ROWS - r : 8);
        end else begin
          w = $urandom_range(1, (mpfd_pkg::SCREEN_COLS - c) < 8 ?
                                mpfd_pkg::SCREEN_COLS - c : 8);
          h = mpfd_pkg::SCREEN_ROWS - r + $urandom_range(0, 1);
        end
        queue_cmd($urandom_range(0, 1) ? mpfd_pkg::OP_FILL : mpfd_pkg::OP_INVERT, c, r, w, h,
                  1'($urandom_range(0, 1)));
      end
    end
    total_cmds = cmd_q.size();

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_results < total_cmds) @(negedge clk_i);
    repeat (END_DRAIN) @(negedge clk_i);
    if (result_due_q.size() != 0)
      report_error($sformatf("%0d expected results never arrived", result_due_q.size()));

    $display("ran %0d commands: %0d set, %0d fill, %0d invert, %0d clear, %0d read, %0d unused",
             n_accepted, op_seen[mpfd_pkg::OP_SET], op_seen[mpfd_pkg::OP_FILL],
             op_seen[mpfd_pkg::OP_INVERT], op_seen[mpfd_pkg::OP_CLEAR],
             op_seen[mpfd_pkg::OP_READ],
             op_seen[OP_SPARE_A] + op_seen[OP_SPARE_B] + op_seen[OP_SPARE_C]);
    $display("%0d rejected off screen, %0d in-bounds reads, one %0d-cycle result hold-off",
             n_rejected, n_reads, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("mono_page_framebuffer_draw: match");
    end else begin
      $display("mono_page_framebuffer_draw: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_TIME);
    $display("mono_page_framebuffer_draw: mismatch");
    $finish;
  end

endmodule
